// ----- design/itl_pkg.sv -----
// Shared types and constants for the IGBT temperature linearizer.
// Depends on nothing; imported by igbt_temperature_linearizer.
`default_nettype none

package itl_pkg;

    localparam int SEG_COUNT = 26;
    localparam int SEG_W     = 5;
    localparam int DELTA_W   = 10;   // widest segment is 582 counts

    localparam logic [15:0] TOP_READING  = 16'd26702;
    localparam logic [15:0] FLAT_READING = 16'd16245;
    localparam logic [15:0] MAX_SEG_SPAN = 16'd582;

    localparam logic signed [7:0] TOP_TEMP    = 8'sd100;
    localparam logic signed [7:0] FLAT_TEMP   = -8'sd35;
    localparam logic signed [7:0] BELOW_RANGE = -8'sd124;
    localparam logic signed [7:0] LOWEST_BASE = -8'sd30;
    localparam logic [7:0]        DEG_PER_SEG = 8'd5;

    // Ascending breakpoints, 5 degrees apart
    localparam logic [15:0] KNOTS [SEG_COUNT+1] = '{
        16'd16308, 16'd16387, 16'd16487, 16'd16609, 16'd16759, 16'd16938, 16'd17151,
        16'd17400, 16'd17688, 16'd18017, 16'd18387, 16'd18797, 16'd19247, 16'd19733,
        16'd20250, 16'd20793, 16'd21357, 16'd21933, 16'd22515, 16'd23097, 16'd23671,
        16'd24232, 16'd24775, 16'd25296, 16'd25792, 16'd26261, 16'd26702
    };

    typedef enum logic [1:0] {
        CLS_LINEAR,
        CLS_TOP,
        CLS_FLAT,
        CLS_BELOW
    } range_class_t;

endpackage

`default_nettype wire

// ----- design/igbt_temperature_linearizer.sv -----
// IGBT temperature linearizer: raw sensor word to whole degrees Celsius.
// Depends on itl_pkg (breakpoints, range classes, output constants).
`default_nettype none

// One result word per input word, one word per cycle sustained while temp_stall
// is low. The segment search lands with the word in the s1 register; breakpoint
// subtract and slope lookup fill s2, the slope multiply fills s3, and truncation
// fills the output register that drives temp_valid. Each stage moves whenever
// the one after it is empty or moving, so a stall on the output fills the pipe
// before raw_stall rises and nothing is dropped or repeated. Readings above
// 26702 give 100, 16246..16308 give -35, 16245 and below give -124. Slopes are
// 5/span rounded to SLOPE_FRACTION_BITS fraction bits.
module igbt_temperature_linearizer #(
    parameter int SLOPE_FRACTION_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              raw_valid,
    output logic                   raw_stall,
    input  wire logic [15:0]       raw_reading,
    output logic                   temp_valid,
    input  wire logic              temp_stall,
    output logic signed [7:0]      temperature_c
);
    import itl_pkg::*;

    localparam int F       = SLOPE_FRACTION_BITS;
    localparam int SLOPE_W = F - 2;              // 5/79 < 1/8
    localparam int FRAC_W  = SLOPE_W + DELTA_W;  // product stays below 8.0
    localparam int INT_W   = FRAC_W - F;

    localparam logic [SLOPE_W-1:0] SLOPE [SEG_COUNT] = '{
        SLOPE_W'(((64'd5 << F) + 64'd39)  / 64'd79),
        SLOPE_W'(((64'd5 << F) + 64'd50)  / 64'd100),
        SLOPE_W'(((64'd5 << F) + 64'd61)  / 64'd122),
        SLOPE_W'(((64'd5 << F) + 64'd75)  / 64'd150),
        SLOPE_W'(((64'd5 << F) + 64'd89)  / 64'd179),
        SLOPE_W'(((64'd5 << F) + 64'd106) / 64'd213),
        SLOPE_W'(((64'd5 << F) + 64'd124) / 64'd249),
        SLOPE_W'(((64'd5 << F) + 64'd144) / 64'd288),
        SLOPE_W'(((64'd5 << F) + 64'd164) / 64'd329),
        SLOPE_W'(((64'd5 << F) + 64'd185) / 64'd370),
        SLOPE_W'(((64'd5 << F) + 64'd205) / 64'd410),
        SLOPE_W'(((64'd5 << F) + 64'd225) / 64'd450),
        SLOPE_W'(((64'd5 << F) + 64'd243) / 64'd486),
        SLOPE_W'(((64'd5 << F) + 64'd258) / 64'd517),
        SLOPE_W'(((64'd5 << F) + 64'd271) / 64'd543),
        SLOPE_W'(((64'd5 << F) + 64'd282) / 64'd564),
        SLOPE_W'(((64'd5 << F) + 64'd288) / 64'd576),
        SLOPE_W'(((64'd5 << F) + 64'd291) / 64'd582),
        SLOPE_W'(((64'd5 << F) + 64'd291) / 64'd582),
        SLOPE_W'(((64'd5 << F) + 64'd287) / 64'd574),
        SLOPE_W'(((64'd5 << F) + 64'd280) / 64'd561),
        SLOPE_W'(((64'd5 << F) + 64'd271) / 64'd543),
        SLOPE_W'(((64'd5 << F) + 64'd260) / 64'd521),
        SLOPE_W'(((64'd5 << F) + 64'd248) / 64'd496),
        SLOPE_W'(((64'd5 << F) + 64'd234) / 64'd469),
        SLOPE_W'(((64'd5 << F) + 64'd220) / 64'd441)
    };

    // stage registers
    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    range_class_t              s1_cls_reg, s2_cls_reg, s3_cls_reg;
    logic [15:0]               s1_raw_reg;
    logic [SEG_W-1:0]          s1_seg_reg;
    logic [DELTA_W-1:0]        s2_delta_reg;
    logic [SLOPE_W-1:0]        s2_slope_reg;
    logic signed [7:0]         s2_base_reg, s3_base_reg;
    logic [FRAC_W-1:0]         s3_frac_reg;
    logic signed [7:0]         out_temp_reg;

    logic                      s1_rdy, s2_rdy, s3_rdy, out_rdy;
    range_class_t              s1_cls_next;
    logic [SEG_W-1:0]          s1_seg_next;
    logic [15:0]               s2_diff;
    logic [DELTA_W-1:0]        s2_delta_next;
    logic signed [7:0]         s2_base_next;
    logic [FRAC_W-1:0]         s3_frac_next;
    logic [INT_W-1:0]          frac_int;
    logic [F-1:0]              frac_rem;
    logic signed [8:0]         lin_sum;
    logic signed [8:0]         lin_trunc;
    logic signed [7:0]         out_temp_next;

    assign out_rdy   = !out_valid_reg || !temp_stall;
    assign s3_rdy    = !s3_valid_reg || out_rdy;
    assign s2_rdy    = !s2_valid_reg || s3_rdy;
    assign s1_rdy    = !s1_valid_reg || s2_rdy;
    assign raw_stall = !s1_rdy;

    // stage 1: range class and segment search
    always_comb
    begin
        priority if (raw_reading > TOP_READING)
            s1_cls_next = CLS_TOP;
        else if (raw_reading <= FLAT_READING)
            s1_cls_next = CLS_BELOW;
        else if (raw_reading <= KNOTS[0])
            s1_cls_next = CLS_FLAT;
        else
            s1_cls_next = CLS_LINEAR;

        s1_seg_next = '0;
        for (int i = 1; i < SEG_COUNT; i++)
        begin
            if (raw_reading > KNOTS[i])
                s1_seg_next = SEG_W'(i);
        end
    end

    // stage 2: offset into segment, slope and base temperature
    always_comb
    begin
        s2_diff       = s1_raw_reg - KNOTS[s1_seg_reg];
        s2_delta_next = s2_diff[DELTA_W-1:0];
        s2_base_next  = LOWEST_BASE + signed'(8'(DEG_PER_SEG * 8'(s1_seg_reg)));
    end

    // stage 3: slope multiply
    assign s3_frac_next = FRAC_W'(s2_slope_reg) * FRAC_W'(s2_delta_reg);

    // stage 4: truncate toward zero and pick the result
    always_comb
    begin
        frac_int  = s3_frac_reg[FRAC_W-1:F];
        frac_rem  = s3_frac_reg[F-1:0];
        lin_sum   = 9'(s3_base_reg) + signed'({1'b0, frac_int});
        // negative total with a fraction rounds up toward zero
        if (lin_sum < 0 && frac_rem != '0)
            lin_trunc = lin_sum + 9'sd1;
        else
            lin_trunc = lin_sum;

        unique case (s3_cls_reg)
            CLS_TOP:    out_temp_next = TOP_TEMP;
            CLS_FLAT:   out_temp_next = FLAT_TEMP;
            CLS_BELOW:  out_temp_next = BELOW_RANGE;
            CLS_LINEAR: out_temp_next = lin_trunc[7:0];
            default:    out_temp_next = BELOW_RANGE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
                s1_valid_reg <= raw_valid;
            if (s2_rdy)
                s2_valid_reg <= s1_valid_reg;
            if (s3_rdy)
                s3_valid_reg <= s2_valid_reg;
            if (out_rdy)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && raw_valid)
        begin
            s1_raw_reg <= raw_reading;
            s1_cls_reg <= s1_cls_next;
            s1_seg_reg <= s1_seg_next;
        end
        if (s2_rdy && s1_valid_reg)
        begin
            s2_cls_reg   <= s1_cls_reg;
            s2_delta_reg <= s2_delta_next;
            s2_slope_reg <= SLOPE[s1_seg_reg];
            s2_base_reg  <= s2_base_next;
        end
        if (s3_rdy && s2_valid_reg)
        begin
            s3_cls_reg  <= s2_cls_reg;
            s3_frac_reg <= s3_frac_next;
            s3_base_reg <= s2_base_reg;
        end
        if (out_rdy && s3_valid_reg)
            out_temp_reg <= out_temp_next;
    end

    assign temp_valid    = out_valid_reg;
    assign temperature_c = out_temp_reg;

`ifndef SYNTH
    // a linear word sits above the breakpoint of its segment
    a_seg_below_raw: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_cls_reg == CLS_LINEAR |-> s1_raw_reg > KNOTS[s1_seg_reg])
        else $error("segment breakpoint not below reading");

    // offset never exceeds the widest segment
    a_delta_span: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_cls_reg == CLS_LINEAR |-> {6'd0, s2_delta_reg} <= MAX_SEG_SPAN)
        else $error("segment offset out of span");

    // results stay in the table range or carry the below-range marker
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        temp_valid |-> (temperature_c >= FLAT_TEMP && temperature_c <= TOP_TEMP)
                       || temperature_c == BELOW_RANGE)
        else $error("temperature out of range");

    // input backs up only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        raw_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire
